// ----- rtl/core/ple_pkg.sv -----
// shared types and constants of the positional list engine
`default_nettype none
package ple_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;
	localparam int KIND_W         = 3;
	localparam int POS_W          = 5;
	localparam int ITEM_W         = 32;
	localparam int LEN_W          = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_DELETE = 3'd1,
		KIND_APPEND = 3'd2,
		KIND_REMOVE = 3'd3,
		KIND_SEARCH = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_COUNT,
		IDX_POS,
		IDX_ZERO,
		IDX_DEC,
		IDX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_DN,
		RD_IDX_UP,
		RD_POS
	} rd_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic    load;
		idx_op_t idx_op;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_shift;
		cnt_op_t cnt_op;
		logic    take;
		logic    set_status;
		status_t status;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic  kind_valid;
		kind_t kind;
		logic  pos_gt_cnt;
		logic  pos_lt_cnt;
		logic  full;
		logic  empty;
		logic  idx_gt_pos;
		logic  idx_up_lt_cnt;
		logic  match;
		logic  out_free;
	} dp_flags_t;

endpackage
`default_nettype wire

// ----- rtl/core/ple_cmd_if.sv -----
// operation channel of the positional list engine
`default_nettype none
interface ple_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [4:0]         position;
	logic signed [31:0] item_value;

	modport source (output valid, kind, position, item_value, input ready);
	modport sink (input valid, kind, position, item_value, output ready);
	modport monitor (input valid, ready, kind, position, item_value);
endinterface
`default_nettype wire

// ----- rtl/core/ple_rsp_if.sv -----
// result channel of the positional list engine
`default_nettype none
interface ple_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic [4:0]         list_length;

	modport source (output valid, status, removed_value, list_length, input ready);
	modport sink (input valid, status, removed_value, list_length, output ready);
	modport monitor (input valid, ready, status, removed_value, list_length);
endinterface
`default_nettype wire

// ----- rtl/core/ple_ctrl.sv -----
// sequencer of the positional list engine
`default_nettype none
module ple_ctrl
	import ple_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_ready,
	input  wire dp_flags_t flags,
	output ctrl_cmd_t      ctl
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_CHECK    = 10'b00_0000_0010,
		S_INS_LOOP = 10'b00_0000_0100,
		S_INS_MOVE = 10'b00_0000_1000,
		S_DEL_TAKE = 10'b00_0001_0000,
		S_DEL_LOOP = 10'b00_0010_0000,
		S_DEL_MOVE = 10'b00_0100_0000,
		S_SRCH_RD  = 10'b00_1000_0000,
		S_SRCH_CMP = 10'b01_0000_0000,
		S_FINISH   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd_ready      = 1'b0;
		ctl            = '0;
		ctl.idx_op     = IDX_HOLD;
		ctl.rd_sel     = RD_IDX;
		ctl.cnt_op     = CNT_HOLD;
		ctl.status     = ST_RANGE;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				ctl.set_status = 1'b1;
				state_d        = S_FINISH;
				if (!flags.kind_valid) begin
					ctl.status = ST_RANGE;
				end else begin
					case (flags.kind)
						KIND_INSERT, KIND_APPEND: begin
							if (flags.pos_gt_cnt) begin
								ctl.status = ST_RANGE;
							end else if (flags.full) begin
								ctl.status = ST_FULL;
							end else begin
								ctl.set_status = 1'b0;
								ctl.idx_op     = IDX_COUNT;
								state_d        = S_INS_LOOP;
							end
						end
						KIND_DELETE, KIND_REMOVE: begin
							if (!flags.pos_lt_cnt) begin
								ctl.status = ST_RANGE;
							end else begin
								ctl.set_status = 1'b0;
								ctl.idx_op     = IDX_POS;
								ctl.rd_en      = 1'b1;
								ctl.rd_sel     = RD_POS;
								state_d        = S_DEL_TAKE;
							end
						end
						KIND_SEARCH: begin
							if (flags.empty) begin
								ctl.status = ST_MISS;
							end else begin
								ctl.set_status = 1'b0;
								ctl.idx_op     = IDX_ZERO;
								state_d        = S_SRCH_RD;
							end
						end
						default: begin
							ctl.status = ST_RANGE;
						end
					endcase
				end
			end
			S_INS_LOOP: begin
				if (flags.idx_gt_pos) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX_DN;
					state_d    = S_INS_MOVE;
				end else begin
					ctl.wr_en      = 1'b1;
					ctl.cnt_op     = CNT_INC;
					ctl.set_status = 1'b1;
					ctl.status     = ST_DONE;
					state_d        = S_FINISH;
				end
			end
			S_INS_MOVE: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_shift = 1'b1;
				ctl.idx_op   = IDX_DEC;
				state_d      = S_INS_LOOP;
			end
			S_DEL_TAKE: begin
				ctl.take = 1'b1;
				state_d  = S_DEL_LOOP;
			end
			S_DEL_LOOP: begin
				if (flags.idx_up_lt_cnt) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_sel = RD_IDX_UP;
					state_d    = S_DEL_MOVE;
				end else begin
					ctl.cnt_op     = CNT_DEC;
					ctl.set_status = 1'b1;
					ctl.status     = ST_DONE;
					state_d        = S_FINISH;
				end
			end
			S_DEL_MOVE: begin
				ctl.wr_en    = 1'b1;
				ctl.wr_shift = 1'b1;
				ctl.idx_op   = IDX_INC;
				state_d      = S_DEL_LOOP;
			end
			S_SRCH_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_IDX;
				state_d    = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (flags.match) begin
					ctl.set_status = 1'b1;
					ctl.status     = ST_DONE;
					state_d        = S_FINISH;
				end else if (flags.idx_up_lt_cnt) begin
					ctl.idx_op = IDX_INC;
					state_d    = S_SRCH_RD;
				end else begin
					ctl.set_status = 1'b1;
					ctl.status     = ST_MISS;
					state_d        = S_FINISH;
				end
			end
			S_FINISH: begin
				if (flags.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/ple_dpath.sv -----
// entry memory, counters and result register of the positional list engine
`default_nettype none
module ple_dpath
	import ple_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [POS_W-1:0]   position,
	input  wire logic signed [ITEM_W-1:0] item_value,
	input  wire ctrl_cmd_t          ctl,
	output dp_flags_t               flags,
	ple_rsp_if.source               rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int IDX_W = $clog2(CAPACITY);

	logic [VALUE_BITS-1:0] mem_q [CAPACITY];
	logic [VALUE_BITS-1:0] rd_data_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [KIND_W-1:0]     kind_q;
	logic [CMP_W-1:0]      pos_q;
	logic [CMP_W-1:0]      count_q;
	logic [CMP_W-1:0]      idx_q;
	logic [ITEM_W-1:0]     removed_q;
	status_t               status_q;
	logic                  rsp_valid_q;
	logic [1:0]            rsp_status_q;
	logic [ITEM_W-1:0]     rsp_removed_q;
	logic [LEN_W-1:0]      rsp_length_q;

	logic [CMP_W-1:0]      rd_addr;
	logic [CMP_W-1:0]      idx_up;
	logic [CMP_W-1:0]      load_pos;
	logic [VALUE_BITS-1:0] wr_data;

	assign idx_up = idx_q + CMP_W'(1);

	always_comb begin
		case (kind_t'(kind))
			KIND_APPEND: load_pos = count_q;
			KIND_REMOVE: load_pos = count_q - CMP_W'(1);
			default:     load_pos = CMP_W'(position);
		endcase
	end

	always_comb begin
		case (ctl.rd_sel)
			RD_IDX_DN: rd_addr = idx_q - CMP_W'(1);
			RD_IDX_UP: rd_addr = idx_up;
			RD_POS:    rd_addr = pos_q;
			default:   rd_addr = idx_q;
		endcase
	end

	assign wr_data = ctl.wr_shift ? rd_data_q : val_q;

	// entry memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[idx_q[IDX_W-1:0]] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q    <= kind;
			pos_q     <= load_pos;
			val_q     <= VALUE_BITS'($signed(item_value));
			removed_q <= '0;
		end else if (ctl.take) begin
			removed_q <= ITEM_W'($signed(rd_data_q));
		end
		if (ctl.set_status) begin
			status_q <= ctl.status;
		end
		case (ctl.idx_op)
			IDX_COUNT: idx_q <= count_q;
			IDX_POS:   idx_q <= pos_q;
			IDX_ZERO:  idx_q <= '0;
			IDX_DEC:   idx_q <= idx_q - CMP_W'(1);
			IDX_INC:   idx_q <= idx_up;
			default:   idx_q <= idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (ctl.cnt_op)
				CNT_INC: count_q <= count_q + CMP_W'(1);
				CNT_DEC: count_q <= count_q - CMP_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_status_q  <= status_q;
			rsp_removed_q <= removed_q;
			rsp_length_q  <= count_q[LEN_W-1:0];
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_value = rsp_removed_q;
	assign rsp.list_length   = rsp_length_q;

	always_comb begin
		flags               = '0;
		flags.kind_valid    = (kind_q <= KIND_W'(KIND_SEARCH));
		flags.kind          = kind_t'(kind_q);
		flags.pos_gt_cnt    = (pos_q > count_q);
		flags.pos_lt_cnt    = (pos_q < count_q);
		flags.full          = (count_q >= CMP_W'(CAPACITY));
		flags.empty         = (count_q == '0);
		flags.idx_gt_pos    = (idx_q > pos_q);
		flags.idx_up_lt_cnt = (idx_up < count_q);
		flags.match         = (rd_data_q == val_q);
		flags.out_free      = !rsp_valid_q || rsp.ready;
	end

endmodule
`default_nettype wire

// ----- rtl/core/positional_list_engine.sv -----
// top level of the positional list engine
// usage:
//   cmd carries one operation a beat: kind, position and item_value
//   rsp carries one result a beat: status, removed_value, list_length
//   the list lives in an entry memory with one write and one registered read
//   port; shifting moves one entry at a time (read, then write), and search
//   reads one entry at a time
// insert/append shift the entries from the target position onward back by one;
//   delete/remove shift the entries behind the target position forward by one;
//   search reads from the head until a match or the end of the list
// throughput: one operation at a time; cmd ready is high only when idle
//   the next cmd beat is taken while the previous result still waits on rsp
// reset clears the length to zero; entry contents are not cleared and are
//   never read before being written
// a stalled rsp holds its beat; a finished operation waits for the slot
//   before going idle
`default_nettype none
module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ple_cmd_if.sink   cmd,
	ple_rsp_if.source rsp
);

	ctrl_cmd_t ctl;
	dp_flags_t flags;
	logic      ready;

	assign cmd.ready = ready;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (ready),
		.flags     (flags),
		.ctl       (ctl)
	);

	ple_dpath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (cmd.kind),
		.position   (cmd.position),
		.item_value (cmd.item_value),
		.ctl        (ctl),
		.flags      (flags),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// ----- rtl/core/ple_checker.sv -----
// port checker of the positional list engine and its bind
`default_nettype none
module ple_checker
	import ple_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [1:0]        rsp_status,
	input wire logic [ITEM_W-1:0] rsp_removed_value,
	input wire logic [LEN_W-1:0]  rsp_list_length
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_removed_value)
			&& $stable(rsp_list_length))
		else $error("rsp payload changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("cmd taken while an operation is in progress");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_list_length == LEN_W'(CAPACITY))
		else $error("full status with a length other than capacity");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_DONE |-> rsp_removed_value == '0)
		else $error("removed value set on a failed operation");

endmodule

bind positional_list_engine ple_checker #(
	.CAPACITY (CAPACITY)
) u_ple_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cmd_valid         (cmd.valid),
	.cmd_ready         (cmd.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_removed_value (rsp.removed_value),
	.rsp_list_length   (rsp.list_length)
);
`default_nettype wire
